### hw/rtl/gf2m_pkg.sv
// shared definitions for the gf(2^m) polynomial basis alu
// operation codes and reset constants; no dependencies
package gf2m_pkg;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_MUL     = 3'd1,
      OP_TRACE   = 3'd2,
      OP_POWER   = 3'd3,
      OP_INVERSE = 3'd4
   } op_type;

   localparam int unsigned DEF_FIELD_DEGREE = 32;
   localparam int unsigned GEN_WIDTH        = 33;
   localparam logic [GEN_WIDTH-1:0] GEN_RESET = 33'h1_0040_0007;
   localparam int unsigned ELEM_IO_WIDTH    = 32;

endpackage

### hw/rtl/gf2m_polynomial_basis_alu.sv
// gf(2^m) polynomial basis alu: add, multiply, trace, power, inverse
// fully pipelined square and multiply chain; uses gf2m_pkg
//
// usage
//   req channel (req_valid/req_ready) takes one beat per cycle when ready:
//   req_type, req_operand_a, req_operand_b. rsp channel (rsp_valid/rsp_ready)
//   returns one beat per request with rsp_result, in request order.
//   csr_wr_en/csr_wr_data write the field generator; write it only while
//   the pipeline is empty.
// pipeline structure
//   every beat passes one setup stage and 2*max(32,FIELD_DEGREE) chain
//   stages (a squaring stage then a multiply stage per exponent bit). one
//   beat enters per cycle unless the chain holds; each chain stage holds
//   one field multiplier.
// reset
//   synchronous reset empties the pipeline and loads the generator
//   x^32+x^22+x^2+x+1.
// stalls
//   when the output beat is not taken the whole chain holds and req_ready
//   drops; nothing is lost or repeated.
module gf2m_polynomial_basis_alu
   import gf2m_pkg::*;
#(
   parameter int unsigned FIELD_DEGREE = DEF_FIELD_DEGREE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_type,
   input  logic [ELEM_IO_WIDTH-1:0] req_operand_a,
   input  logic [ELEM_IO_WIDTH-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ELEM_IO_WIDTH-1:0] rsp_result,
   input  logic                     csr_wr_en,
   input  logic [GEN_WIDTH-1:0]     csr_wr_data
);

   localparam int unsigned M     = FIELD_DEGREE;
   localparam int unsigned NSTEP = (M > ELEM_IO_WIDTH) ? M : ELEM_IO_WIDTH;
   localparam int unsigned GW    = (M > GEN_WIDTH) ? M : GEN_WIDTH;
   localparam int unsigned LAST  = 2 * NSTEP;

   typedef logic [M-1:0]     elem_type;
   typedef logic [NSTEP-1:0] expo_type;

   function automatic elem_type f_xtime(elem_type r, elem_type t);
      elem_type s;
      s = {r[M-2:0], 1'b0};
      if (r[M-1]) s = s ^ t;
      return s;
   endfunction

   function automatic elem_type f_mul(elem_type a, elem_type b, elem_type t);
      elem_type r;
      r = '0;
      for (int i = M - 1; i >= 0; i--) begin
         r = f_xtime(r, t);
         if (b[i]) r = r ^ a;
      end
      return r;
   endfunction

   // fold input bits at or above x^m back in
   function automatic elem_type f_reduce_in(logic [ELEM_IO_WIDTH-1:0] v_raw, elem_type t);
      logic [NSTEP-1:0] v;
      logic [NSTEP-1:0] te;
      v  = NSTEP'(v_raw);
      te = NSTEP'(t);
      for (int i = NSTEP - 1; i >= int'(M); i--) begin
         if (v[i]) begin
            v[i] = 1'b0;
            v    = v ^ (te << (i - int'(M)));
         end
      end
      return v[M-1:0];
   endfunction

   logic [GW-1:0] gen_wide_reset;
   logic [GW-1:0] gen_wide_wr;
   elem_type      tail_ff;
   elem_type      tail_in;

   assign gen_wide_reset = GW'(GEN_RESET);
   assign gen_wide_wr    = GW'(csr_wr_data);
   assign tail_in        = gen_wide_wr[M-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= gen_wide_reset[M-1:0];
      end else if (csr_wr_en) begin
         tail_ff <= tail_in;
      end
   end

   logic     valid_ff [0:LAST];
   elem_type c_ff     [0:LAST];
   elem_type acc_ff   [0:LAST];
   elem_type a_ff     [0:LAST];
   expo_type e_ff     [0:LAST];
   logic     sq_ff    [0:LAST];
   logic     tr_ff    [0:LAST];

   elem_type c_in     [0:LAST];
   elem_type acc_in   [0:LAST];
   expo_type e_in     [0:LAST];

   logic adv;
   assign adv       = !valid_ff[LAST] || rsp_ready;
   assign req_ready = adv;

   // setup stage
   elem_type a_red;
   elem_type b_red;
   logic     sq_in;
   logic     tr_in;
   logic [NSTEP:0] inv_exp;

   assign a_red   = f_reduce_in(req_operand_a, tail_ff);
   assign b_red   = f_reduce_in(req_operand_b, tail_ff);
   assign inv_exp = ((NSTEP+1)'(1) << M) - (NSTEP+1)'(2);

   always_comb begin
      c_in[0]   = '0;
      acc_in[0] = '0;
      e_in[0]   = '0;
      sq_in     = 1'b0;
      tr_in     = 1'b0;
      case (req_type)
         OP_ADD: begin
            c_in[0] = a_red ^ b_red;
         end
         OP_MUL: begin
            c_in[0] = b_red;
            e_in[0] = expo_type'(1);
         end
         OP_TRACE: begin
            c_in[0] = a_red;
            sq_in   = 1'b1;
            tr_in   = 1'b1;
         end
         OP_POWER: begin
            c_in[0] = elem_type'(1);
            e_in[0] = expo_type'(req_operand_b);
            sq_in   = 1'b1;
         end
         OP_INVERSE: begin
            c_in[0] = elem_type'(1);
            e_in[0] = inv_exp[NSTEP-1:0];
            sq_in   = 1'b1;
         end
         default: begin
            c_in[0] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff[0]   <= c_in[0];
         acc_ff[0] <= acc_in[0];
         a_ff[0]   <= a_red;
         e_ff[0]   <= e_in[0];
         sq_ff[0]  <= sq_in;
         tr_ff[0]  <= tr_in;
      end
   end

   // chain: odd stages square when enabled and add to the trace sum, even stages multiply by a on exponent bit
   for (genvar s = 1; s <= LAST; s++) begin : g_stage
      localparam int unsigned K = (s - 1) / 2;
      if (s % 2 == 1) begin : g_sq
         always_comb begin
            c_in[s]   = c_ff[s-1];
            acc_in[s] = acc_ff[s-1];
            e_in[s]   = e_ff[s-1];
            if (sq_ff[s-1] && (!tr_ff[s-1] || K < M)) begin
               if (tr_ff[s-1]) acc_in[s] = acc_ff[s-1] ^ c_ff[s-1];
               c_in[s] = f_mul(c_ff[s-1], c_ff[s-1], tail_ff);
            end
         end
      end else begin : g_mul
         always_comb begin
            c_in[s]   = c_ff[s-1];
            acc_in[s] = acc_ff[s-1];
            e_in[s]   = {e_ff[s-1][NSTEP-2:0], 1'b0};
            if (e_ff[s-1][NSTEP-1]) begin
               c_in[s] = f_mul(c_ff[s-1], a_ff[s-1], tail_ff);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            c_ff[s]   <= c_in[s];
            acc_ff[s] <= acc_in[s];
            a_ff[s]   <= a_ff[s-1];
            e_ff[s]   <= e_in[s];
            sq_ff[s]  <= sq_ff[s-1];
            tr_ff[s]  <= tr_ff[s-1];
         end
      end
   end

   logic [NSTEP-1:0] res_wide;
   assign res_wide   = NSTEP'(tr_ff[LAST] ? acc_ff[LAST] : c_ff[LAST]);
   assign rsp_result = res_wide[ELEM_IO_WIDTH-1:0];
   assign rsp_valid  = valid_ff[LAST];

endmodule

### tb/gf2m_alu_checker.sv
// result checker for the gf(2^m) polynomial basis alu: predicts each response
// from the accepted request beats and the current generator; uses gf2m_pkg
`timescale 1ns / 100ps
module gf2m_alu_checker
   import gf2m_pkg::*;
#(
   parameter int unsigned FIELD_DEGREE = DEF_FIELD_DEGREE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [2:0]               req_type,
   input  logic [ELEM_IO_WIDTH-1:0] req_operand_a,
   input  logic [ELEM_IO_WIDTH-1:0] req_operand_b,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [ELEM_IO_WIDTH-1:0] rsp_result,
   input  logic                     csr_wr_en,
   input  logic [GEN_WIDTH-1:0]     csr_wr_data,
   output int                       fail_count,
   output int                       pending_count
);

   localparam int M = FIELD_DEGREE;

   logic [63:0] field_tail;
   logic [31:0] expected_results[$];
   int          mismatches;

   function automatic logic [63:0] elem_mask();
      return (64'd1 << M) - 64'd1;
   endfunction

   function automatic logic [63:0] fold_input(logic [63:0] v);
      v &= 64'hFFFF_FFFF;
      for (int i = 31; i >= M; i--) begin
         if (v[i]) begin
            v[i] = 1'b0;
            v ^= field_tail << (i - M);
         end
      end
      return v & elem_mask();
   endfunction

   function automatic logic [63:0] field_mul(logic [63:0] a, logic [63:0] b);
      logic [63:0] acc;
      logic        top;
      acc = 0;
      for (int i = M - 1; i >= 0; i--) begin
         top = acc[M-1];
         acc = (acc << 1) & elem_mask();
         if (top) acc ^= field_tail;
         if (b[i]) acc ^= a;
      end
      return acc & elem_mask();
   endfunction

   function automatic logic [63:0] field_pow(logic [63:0] a, logic [63:0] e, int nbits);
      logic [63:0] c;
      c = 1;
      for (int i = nbits - 1; i >= 0; i--) begin
         c = field_mul(c, c);
         if (e[i]) c = field_mul(c, a);
      end
      return c & elem_mask();
   endfunction

   function automatic logic [31:0] predict_result(logic [2:0] op, logic [31:0] ra,
                                                  logic [31:0] rb);
      logic [63:0] a, d, acc;
      a = fold_input({32'd0, ra});
      acc = 0;
      case (op)
         OP_ADD:     acc = a ^ fold_input({32'd0, rb});
         OP_MUL:     acc = field_mul(a, fold_input({32'd0, rb}));
         OP_TRACE: begin
            d = a;
            for (int i = 0; i < M; i++) begin
               acc ^= d;
               d = field_mul(d, d);
            end
         end
         OP_POWER:   acc = field_pow(a, {32'd0, rb}, 32);
         OP_INVERSE: acc = field_pow(a, elem_mask() - 1, M);
         default:    acc = 0;
      endcase
      return acc[31:0];
   endfunction

   assign fail_count    = mismatches;
   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      if (reset) begin
         field_tail <= GEN_RESET & elem_mask();
         mismatches <= 0;
         expected_results.delete();
      end else begin
         if (csr_wr_en) field_tail <= {31'd0, csr_wr_data} & elem_mask();
         if (req_valid && req_ready)
            expected_results.insert(expected_results.size(),
                                    predict_result(req_type, req_operand_a, req_operand_b));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (mismatches < 10) $display("unexpected result beat %h", rsp_result);
               mismatches <= mismatches + 1;
            end else begin
               if (expected_results[0] !== rsp_result) begin
                  if (mismatches < 10)
                     $display("result mismatch: expected %h actual %h",
                              expected_results[0], rsp_result);
                  mismatches <= mismatches + 1;
               end
               void'(expected_results.pop_front());
            end
         end
      end
   end

endmodule

### tb/gf2m_polynomial_basis_alu_tb.sv
// testbench top for the gf(2^m) polynomial basis alu: clock, reset, request
// stimulus, generator writes and verdict; uses gf2m_pkg and gf2m_alu_checker
`timescale 1ns / 100ps
module gf2m_polynomial_basis_alu_tb;
   import gf2m_pkg::*;

   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT  = 20000;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic [2:0]               req_type = 0;
   logic [ELEM_IO_WIDTH-1:0] req_operand_a = 0;
   logic [ELEM_IO_WIDTH-1:0] req_operand_b = 0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic [ELEM_IO_WIDTH-1:0] rsp_result;
   logic                     csr_wr_en = 0;
   logic [GEN_WIDTH-1:0]     csr_wr_data = 0;
   int                       fail_count, pending_count;
   int                       send_idle_pct = 0, recv_idle_pct = 0;
   bit                       hold_off = 0;
   int                       quiet_cycles = 0;

   always #5 clock = ~clock;

   gf2m_polynomial_basis_alu u_top (.*);
   gf2m_alu_checker u_checker (.*);

   // receiver: random stalls, plus a long hold-off when asked
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // valid stays high from one beat to the next unless the sender idles
   task automatic send_beat(logic [2:0] op, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid     <= 1;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_generator(logic [32:0] g);
      csr_wr_en   <= 1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd1 << $urandom_range(31);
         3: return $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_beats(int n);
      logic [2:0] op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         send_beat(op, rand_operand(), rand_operand());
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 72;

      // directed: every operation at the operand extremes, both special zero cases, and the undefined op codes
      send_beat(OP_ADD, 32'hFFFF_FFFF, 32'h0);
      send_beat(OP_ADD, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
      send_beat(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_MUL, 32'h8000_0000, 32'h2);
      send_beat(OP_MUL, 32'h0, 32'h1234_5678);
      send_beat(OP_TRACE, 32'h1, 32'hFFFF_FFFF);
      send_beat(OP_TRACE, 32'hFFFF_FFFF, 32'h0);
      send_beat(OP_POWER, 32'h0, 32'h0);
      send_beat(OP_POWER, 32'h1234_5678, 32'h0);
      send_beat(OP_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_POWER, 32'h0, 32'h5);
      send_beat(OP_INVERSE, 32'h0, 32'hFFFF_FFFF);
      send_beat(OP_INVERSE, 32'h1, 32'h0);
      send_beat(OP_INVERSE, 32'hFFFF_FFFF, 32'h0);
      send_beat(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(3'd6, 32'h1, 32'h1);
      send_beat(3'd7, 32'h0, 32'h0);

      // long receiver hold-off while the sender keeps offering beats
      fork
         begin
            hold_off = 1;
            repeat (200) @(negedge clock);
            hold_off = 0;
         end
         random_beats(90);
      join

      random_beats(150);
      drain();
      // reducible generator and the all-zero tail: arithmetic still defined
      write_generator(33'h0_0000_0000);
      random_beats(30);
      drain();

      send_idle_pct = 72;
      recv_idle_pct = 34;
      write_generator(33'h1_FFFF_FFFF);
      random_beats(30);
      drain();
      write_generator(33'h0_0000_008D);   // x^32+x^7+x^3+x^2+1, top bit left clear
      random_beats(150);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_generator({1'b1, 32'($urandom)});
      random_beats(50);
      drain();
      write_generator(GEN_RESET);
      random_beats(150);
      drain();

      if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

### gf2m_polynomial_basis_alu.f
hw/rtl/gf2m_pkg.sv
hw/rtl/gf2m_polynomial_basis_alu.sv
tb/gf2m_alu_checker.sv
tb/gf2m_polynomial_basis_alu_tb.sv
